[hdl/link_loss_transmit_throttle_defines.svh]
// Assertion macros for the link-loss transmit throttle checker.
`ifndef LINK_LOSS_TRANSMIT_THROTTLE_DEFINES_SVH
`define LINK_LOSS_TRANSMIT_THROTTLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/llt_pkg.sv]
// Shared types and constants of the link-loss transmit throttle.
package llt_pkg;

	localparam logic [1:0] MODE_NORMAL    = 2'd0;
	localparam logic [1:0] MODE_FREEZE    = 2'd1;
	localparam logic [1:0] MODE_RECOVERY  = 2'd2;
	localparam logic [1:0] MODE_EMERGENCY = 2'd3;

	localparam logic [2:0] CMD_TICK      = 3'd0;
	localparam logic [2:0] CMD_HEARTBEAT = 3'd1;
	localparam logic [2:0] CMD_UPDATE    = 3'd2;
	localparam logic [2:0] CMD_FREEZE    = 3'd3;
	localparam logic [2:0] CMD_QUERY     = 3'd4;
	localparam logic [2:0] CMD_REINIT    = 3'd5;
	localparam logic [2:0] CMD_SEED      = 3'd6;
	localparam logic [2:0] CMD_SPARE     = 3'd7;

	localparam logic [2:0] REG_TIMEOUT   = 3'd0;
	localparam logic [2:0] REG_FLIMIT    = 3'd1;
	localparam logic [2:0] REG_RECOVERY  = 3'd2;
	localparam logic [2:0] REG_PPERIOD   = 3'd3;
	localparam logic [2:0] REG_PSTEP     = 3'd4;
	localparam logic [2:0] REG_MINPROB   = 3'd5;
	localparam logic [2:0] REG_ETHRESH   = 3'd6;

	localparam logic [16:0] ONE_Q16       = 17'd65536;
	localparam logic [16:0] HALF_Q16      = 17'd32768;
	localparam logic [16:0] EMERG_PENALTY = 17'd58982;
	localparam logic [31:0] RNG_DEFAULT   = 32'h12345678;
	localparam logic [15:0] DRAW_MOD      = 16'd1000;
	localparam logic [31:0] DRAW_RECIP    = 32'd2199023256;
	localparam logic [15:0] CNT_MAX       = 16'hFFFF;

	typedef struct packed {
		logic [15:0] timeout;
		logic [31:0] flimit;
		logic [15:0] rec;
		logic [31:0] pperiod;
		logic [16:0] pstep;
		logic [16:0] minp;
		logic [15:0] ethr;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic upd;
		logic mul;
		logic prd;
		logic div_start;
		logic cap_quot;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_hold;
	} stat_t;

endpackage

[hdl/link_loss_transmit_throttle.sv]
// Top level: APB register file, controller and datapath of the link-loss throttle.
// A request is loaded in IDLE and passes the UPD, MUL and PRD states to FIN, which registers
// the result; a recovery ramp is first interpolated by the bit-serial divider (DIVS, DIVW).
// One request at a time: in_ready is low until FIN completes, and FIN waits while the
// previous result still waits for out_ready.
// Reset: asynchronous, active low; machine, configuration registers and counters return to reset values.
module link_loss_transmit_throttle (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [31:0] now_ms,
	input  logic [16:0] shapley,
	input  logic [15:0] energy,
	input  logic [31:0] seed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  mode,
	output logic [16:0] probability,
	output logic        transmit,
	output logic        frozen,
	output logic [16:0] penalty,
	output logic [15:0] freeze_events,
	output logic [15:0] recoveries,
	output logic [15:0] packets_in_freeze,
	output logic [31:0] since_heartbeat_ms
);
	import llt_pkg::*;

	cfg_t       cfg_q;
	cmd_t       ctl;
	stat_t      st;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout <= 16'd500;
			cfg_q.flimit  <= 32'd1800000;
			cfg_q.rec     <= 16'd2000;
			cfg_q.pperiod <= 32'd60000;
			cfg_q.pstep   <= 17'd6554;
			cfg_q.minp    <= 17'd3277;
			cfg_q.ethr    <= 16'd0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_TIMEOUT:  cfg_q.timeout <= pwdata[15:0];
				REG_FLIMIT:   cfg_q.flimit  <= pwdata;
				REG_RECOVERY: cfg_q.rec     <= pwdata[15:0];
				REG_PPERIOD:  cfg_q.pperiod <= pwdata;
				REG_PSTEP:    cfg_q.pstep   <= pwdata[16:0];
				REG_MINPROB:  cfg_q.minp    <= pwdata[16:0];
				REG_ETHRESH:  cfg_q.ethr    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TIMEOUT:  prdata = {16'b0, cfg_q.timeout};
			REG_FLIMIT:   prdata = cfg_q.flimit;
			REG_RECOVERY: prdata = {16'b0, cfg_q.rec};
			REG_PPERIOD:  prdata = cfg_q.pperiod;
			REG_PSTEP:    prdata = {15'b0, cfg_q.pstep};
			REG_MINPROB:  prdata = {15'b0, cfg_q.minp};
			REG_ETHRESH:  prdata = {16'b0, cfg_q.ethr};
			default:      prdata = '0;
		endcase
	end

	llt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (st),
		.cmd      (ctl)
	);

	llt_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.cmd                (ctl),
		.stat               (st),
		.cmd_in             (cmd),
		.now_ms             (now_ms),
		.shapley            (shapley),
		.energy             (energy),
		.seed               (seed),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.mode               (mode),
		.probability        (probability),
		.transmit           (transmit),
		.frozen             (frozen),
		.penalty            (penalty),
		.freeze_events      (freeze_events),
		.recoveries         (recoveries),
		.packets_in_freeze  (packets_in_freeze),
		.since_heartbeat_ms (since_heartbeat_ms)
	);
endmodule

[hdl/llt_div.sv]
// Restoring divider, one quotient bit per cycle.
module llt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [15:0] divisor,
	output logic [32:0] quotient,
	output logic        done
);
	logic [32:0] quo_q;
	logic [15:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        fit;

	assign trial = {rem_q, quo_q[32]};
	assign fit   = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd32) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[31:0], fit};
			rem_q <= fit ? diff[15:0] : trial[15:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

[hdl/llt_ctrl.sv]
// Controller state machine sequencing one request through the datapath.
module llt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  llt_pkg::stat_t stat,
	output llt_pkg::cmd_t  cmd
);
	import llt_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_PRD  = 3'd3;
	localparam logic [2:0] ST_DIVS = 3'd4;
	localparam logic [2:0] ST_DIVW = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_PRD;
			end
			ST_PRD: begin
				cmd.prd = 1'b1;
				state_d = stat.need_div ? ST_DIVS : ST_FIN;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (stat.div_done) begin
					cmd.cap_quot = 1'b1;
					state_d      = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!stat.out_hold) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == ST_IDLE;
endmodule

[hdl/llt_dp.sv]
// Datapath: machine state, probability arithmetic and result register.
module llt_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  llt_pkg::cfg_t  cfg,
	input  llt_pkg::cmd_t  cmd,
	output llt_pkg::stat_t stat,
	input  logic [2:0]     cmd_in,
	input  logic [31:0]    now_ms,
	input  logic [16:0]    shapley,
	input  logic [15:0]    energy,
	input  logic [31:0]    seed,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     mode,
	output logic [16:0]    probability,
	output logic           transmit,
	output logic           frozen,
	output logic [16:0]    penalty,
	output logic [15:0]    freeze_events,
	output logic [15:0]    recoveries,
	output logic [15:0]    packets_in_freeze,
	output logic [31:0]    since_heartbeat_ms
);
	import llt_pkg::*;

	logic [2:0]  cmd_q;
	logic [31:0] now_q;
	logic [16:0] shap_q;
	logic [15:0] energy_q;
	logic [31:0] seed_q;

	logic [1:0]  mode_q;
	logic [31:0] last_hb_q, fstart_q, rstart_q, lpen_q, rng_q;
	logic [16:0] held_q, pen_q;
	logic [1:0]  run_q;
	logic [15:0] fcnt_q, rcnt_q, gcnt_q;

	logic [16:0] f_q, quot_q;
	logic [15:0] d_q;
	logic [32:0] prod_q;
	logic [22:0] rquo_q;
	logic [9:0]  rmod_q;
	logic        out_valid_q;

	logic [31:0] x1, x2, x3, elapsed, dd;
	logic [1:0]  run_inc;
	logic [16:0] cap, rem17, diff;
	logic [17:0] psum, pr;
	logic [33:0] prodf;
	logic        is_frozen, tx, need_mod;
	logic [26:0] pk;
	logic [16:0] prob;
	logic [63:0] rq_prod;
	logic [31:0] rback, rdiff;
	logic [32:0] div_quo;
	logic        div_done;

	assign x1      = rng_q ^ (rng_q << 13);
	assign x2      = x1 ^ (x1 >> 17);
	assign x3      = x2 ^ (x2 << 5);
	assign elapsed = now_q - last_hb_q;
	assign dd      = now_q - rstart_q;
	assign run_inc = (run_q == 2'd3) ? 2'd3 : run_q + 2'd1;
	assign cap     = (cfg.minp > ONE_Q16) ? 17'd0 : ONE_Q16 - cfg.minp;
	assign psum    = {1'b0, pen_q} + {1'b0, cfg.pstep};
	assign rem17   = (pen_q >= ONE_Q16) ? 17'd0 : ONE_Q16 - pen_q;
	assign prodf   = {17'b0, held_q} * {17'b0, rem17};
	assign diff    = (shap_q >= f_q) ? shap_q - f_q : f_q - shap_q;
	assign is_frozen = mode_q == MODE_FREEZE || mode_q == MODE_EMERGENCY;
	assign need_mod  = cmd_q == CMD_QUERY && energy_q >= cfg.ethr;

	assign rq_prod = {32'b0, rng_q} * {32'b0, DRAW_RECIP};
	assign rback   = {9'b0, rquo_q} * {16'b0, DRAW_MOD};
	assign rdiff   = rng_q - rback;

	assign stat.need_div = mode_q == MODE_RECOVERY && cfg.rec != 16'd0 && dd < {16'b0, cfg.rec};
	assign stat.div_done = div_done;
	assign stat.out_hold = out_valid_q && !out_ready;

	llt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (cfg.rec),
		.quotient (div_quo),
		.done     (div_done)
	);

	always_comb begin
		case (mode_q)
			MODE_NORMAL:   pr = {1'b0, shap_q};
			MODE_FREEZE:   pr = {1'b0, (f_q < cfg.minp) ? cfg.minp : f_q};
			MODE_RECOVERY: begin
				if (stat.need_div) begin
					pr = (shap_q >= f_q) ? {1'b0, f_q} + {1'b0, quot_q}
						: {1'b0, f_q} - {1'b0, quot_q};
				end else begin
					pr = {1'b0, shap_q};
				end
			end
			default:       pr = {1'b0, cfg.minp};
		endcase
	end

	assign prob = (pr > {1'b0, ONE_Q16}) ? ONE_Q16 : pr[16:0];
	assign pk   = {10'b0, prob} * 27'd1000;
	assign tx   = need_mod && ({1'b0, rmod_q, 16'b0} < pk);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= cmd_in;
			now_q    <= now_ms;
			shap_q   <= shapley;
			energy_q <= energy;
			seed_q   <= seed;
		end
		if (cmd.mul) begin
			f_q    <= prodf[32:16];
			d_q    <= dd[15:0];
			rquo_q <= rq_prod[63:41];
		end
		if (cmd.prd) begin
			prod_q <= {16'b0, diff} * {17'b0, d_q};
			rmod_q <= rdiff[9:0];
		end
		if (cmd.cap_quot) begin
			quot_q <= div_quo[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			last_hb_q <= '0;
			fstart_q  <= '0;
			rstart_q  <= '0;
			lpen_q    <= '0;
			held_q    <= HALF_Q16;
			pen_q     <= '0;
			run_q     <= '0;
			rng_q     <= RNG_DEFAULT;
			fcnt_q    <= '0;
			rcnt_q    <= '0;
			gcnt_q    <= '0;
		end else if (cmd.upd) begin
			case (cmd_q)
				CMD_TICK: begin
					if (mode_q == MODE_NORMAL || mode_q == MODE_RECOVERY) begin
						if (elapsed > {16'b0, cfg.timeout}) begin
							mode_q   <= MODE_FREEZE;
							fstart_q <= now_q;
							lpen_q   <= now_q;
							pen_q    <= '0;
							fcnt_q   <= (fcnt_q == CNT_MAX) ? CNT_MAX : fcnt_q + 16'd1;
						end
					end else if (mode_q == MODE_FREEZE) begin
						if (now_q - lpen_q >= cfg.pperiod) begin
							pen_q  <= (psum > {1'b0, cap}) ? cap : psum[16:0];
							lpen_q <= now_q;
						end
						if (now_q - fstart_q > cfg.flimit) begin
							mode_q <= MODE_EMERGENCY;
						end
					end else begin
						pen_q <= EMERG_PENALTY;
					end
				end
				CMD_HEARTBEAT, CMD_UPDATE: begin
					if (cmd_q == CMD_UPDATE && mode_q == MODE_NORMAL) begin
						held_q <= shap_q;
					end
					last_hb_q <= now_q;
					if (is_frozen) begin
						mode_q   <= MODE_RECOVERY;
						rstart_q <= now_q;
						run_q    <= 2'd1;
					end else if (mode_q == MODE_RECOVERY) begin
						run_q <= run_inc;
						if (dd >= {16'b0, cfg.rec} && run_inc >= 2'd2) begin
							mode_q <= MODE_NORMAL;
							pen_q  <= '0;
							rcnt_q <= (rcnt_q == CNT_MAX) ? CNT_MAX : rcnt_q + 16'd1;
						end
					end
				end
				CMD_FREEZE: begin
					if (mode_q != MODE_FREEZE) begin
						mode_q   <= MODE_FREEZE;
						fstart_q <= now_q;
						lpen_q   <= now_q;
						pen_q    <= '0;
						fcnt_q   <= (fcnt_q == CNT_MAX) ? CNT_MAX : fcnt_q + 16'd1;
					end
				end
				CMD_QUERY: begin
					if (energy_q >= cfg.ethr) begin
						rng_q <= x3;
					end
				end
				CMD_REINIT: begin
					mode_q    <= MODE_NORMAL;
					last_hb_q <= now_q;
					fstart_q  <= '0;
					rstart_q  <= '0;
					lpen_q    <= '0;
					held_q    <= HALF_Q16;
					pen_q     <= '0;
					run_q     <= '0;
					fcnt_q    <= '0;
					rcnt_q    <= '0;
					gcnt_q    <= '0;
				end
				CMD_SEED: begin
					rng_q <= (seed_q != 32'd0) ? seed_q : RNG_DEFAULT;
				end
				default: begin
				end
			endcase
		end else if (cmd.fin && tx && is_frozen) begin
			gcnt_q <= (gcnt_q == CNT_MAX) ? CNT_MAX : gcnt_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			mode               <= mode_q;
			probability        <= prob;
			transmit           <= tx;
			frozen             <= is_frozen;
			penalty            <= pen_q;
			freeze_events      <= fcnt_q;
			recoveries         <= rcnt_q;
			packets_in_freeze  <= (tx && is_frozen && gcnt_q != CNT_MAX) ? gcnt_q + 16'd1
				: gcnt_q;
			since_heartbeat_ms <= elapsed;
		end
	end

	assign out_valid = out_valid_q;
endmodule

[hdl/llt_checker.sv]
// Port-level checker for the link-loss transmit throttle, with its bind.
`include "link_loss_transmit_throttle_defines.svh"

module llt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  mode,
	input logic        frozen,
	input logic [16:0] penalty,
	input logic [16:0] probability
);
	import llt_pkg::*;

	`LLT_ASSERT_NXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready)
	`LLT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(probability))
	`LLT_ASSERT_IMP(a_frozen_mode, clk, arst_n, out_valid, frozen == (mode == MODE_FREEZE || mode == MODE_EMERGENCY))
	`LLT_ASSERT_IMP(a_normal_no_pen, clk, arst_n, out_valid && mode == MODE_NORMAL, penalty == 17'd0)
endmodule

bind link_loss_transmit_throttle llt_checker u_chk (.*);
